@@ hdl/pqmx_pkg.sv @@
`timescale 1ns / 1ps
// Package for the max-extract priority queue: request/result transaction
// structs, stored entry type, request codes and default sizing. No dependencies.
package pqmx_pkg;

  localparam int unsigned PQMX_DEPTH = 16;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] proc_id;
    logic [31:0] prio;
  } pqmx_req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] out_id;
    logic [31:0] out_prio;
    logic [4:0]  count;
    logic        is_empty;
  } pqmx_res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] prio;
  } pqmx_entry_t;

endpackage

@@ hdl/priority_queue_max_extract_core.sv @@
`timescale 1ns / 1ps
// Sequence: an enqueue or an empty dequeue runs EXEC then DONE; a dequeue of held
//   entries scans them all, then shifts down those behind the maximum (none at tail).
// One transaction at a time: the next is accepted in the cycle after the result
//   loads, and the load waits while out_stall_i holds an earlier result.
// Reset: asynchronous, active low; queue empty, sequencer idle, no result held.
// Entry memory is not cleared: only slots below the fill count are ever used.
module priority_queue_max_extract_core
  import pqmx_pkg::*;
#(
  parameter int unsigned DEPTH = PQMX_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pqmx_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pqmx_res_t out_data_o
);

  // Address width for the memory, index width able to hold DEPTH itself.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] DEPTH_W = IW'(DEPTH);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  pqmx_req_t     req_q;
  logic [IW-1:0] fill_q, fill_d;
  logic [IW-1:0] rd_ptr_q, rd_ptr_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;
  pqmx_entry_t   best_q, best_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  logic          res_ok_q, res_ok_d;
  logic          out_valid_q;
  pqmx_res_t     out_q;

  // Entry memory: one write port, one registered read port.
  pqmx_entry_t   mem [DEPTH];
  pqmx_entry_t   rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  pqmx_entry_t   wr_data;

  logic          in_acc;
  logic          out_load;
  logic          issue;
  logic [31:0]   fill_ext;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign rd_addr  = rd_ptr_q[AW-1:0];
  assign issue    = (rd_ptr_q < fill_q);
  assign fill_ext = 32'(fill_q);

  // Only one transaction in flight; the output register decouples the far side.
  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    rd_ptr_d   = rd_ptr_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    res_ok_d   = res_ok_q;
    mem_we     = 1'b0;
    wr_addr    = fill_q[AW-1:0];
    wr_data    = '{id: req_q.proc_id, prio: req_q.prio};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        best_d   = '0;
        rd_ptr_d = '0;
        if (req_q.req_type == REQ_ENQ) begin
          // Append at the tail unless full.
          if (fill_q < DEPTH_W) begin
            mem_we   = 1'b1;
            fill_d   = fill_q + IW'(1);
            res_ok_d = 1'b1;
          end else begin
            res_ok_d = 1'b0;
          end
          state_d = S_DONE;
        end else if (fill_q == '0) begin
          res_ok_d = 1'b0;
          state_d  = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // Read one slot per cycle; compare each slot once its registered read data arrives.
        if (issue) begin
          rd_ptr_d   = rd_ptr_q + IW'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q[AW-1:0];
        end
        if (pend_q) begin
          // Strictly greater, so the earliest of equal priorities is kept.
          if (pend_idx_q == '0 || rd_data_q.prio > best_q.prio) begin
            best_d     = rd_data_q;
            best_idx_d = pend_idx_q;
          end
        end
        if (!issue && !pend_q) begin
          rd_ptr_d = IW'(best_idx_q) + IW'(1);
          state_d  = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // Move every entry behind the removed one down by one slot.
        if (issue) begin
          rd_ptr_d   = rd_ptr_q + IW'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q[AW-1:0];
        end
        if (pend_q) begin
          mem_we  = 1'b1;
          wr_addr = pend_idx_q - AW'(1);
          wr_data = rd_data_q;
        end
        if (!issue && !pend_q) begin
          fill_d   = fill_q - IW'(1);
          res_ok_d = 1'b1;
          state_d  = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    pend_idx_q <= pend_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_ok_q   <= res_ok_d;
    if (out_load) begin
      out_q.ok       <= res_ok_q;
      out_q.out_id   <= best_q.id;
      out_q.out_prio <= best_q.prio;
      out_q.count    <= fill_ext[4:0];
      out_q.is_empty <= (fill_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_W)
    else $error("fill count beyond depth");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_EXEC)
    else $error("accepted transaction not executed");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && pend_q) |-> (pend_idx_q != '0) && (IW'(pend_idx_q) < fill_q))
    else $error("shift write outside held entries");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside completion");

endmodule

@@ tb/pqmx_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the max-extract priority queue. It watches both channels,
// keeps its own copy of the queue, predicts each result and compares in order.
// Depends on pqmx_pkg for the transaction structs and the request codes.
module pqmx_checker
  import pqmx_pkg::*;
#(
  parameter int unsigned DEPTH = PQMX_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  pqmx_req_t in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  pqmx_res_t out_data_i,
  output int        err_count_o,
  output int        pending_o
);

  pqmx_entry_t held [DEPTH];
  int unsigned held_fill;
  pqmx_res_t   awaited_res [$];
  pqmx_res_t   want_res;
  int          errs;
  int unsigned res_no;

  task automatic report_mismatch(input string msg);
    errs++;
    $display("pqmx_checker: result %0d: %s", res_no, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Updates the shadow queue and returns the result the request must give.
  function automatic pqmx_res_t apply_request(input pqmx_req_t req);
    pqmx_res_t   res;
    int unsigned best;
    logic [31:0] top_prio;
    res = '0;
    if (req.req_type == REQ_ENQ) begin
      if (held_fill < DEPTH) begin
        held[held_fill].id   = req.proc_id;
        held[held_fill].prio = req.prio;
        held_fill++;
        res.ok = 1'b1;
      end
    end else if (held_fill != 0) begin
      // strict compare: on a tie the oldest entry stays the winner
      best     = 0;
      top_prio = held[0].prio;
      for (int unsigned i = 1; i < held_fill; i++) begin
        if (held[i].prio > top_prio) begin
          top_prio = held[i].prio;
          best     = i;
        end
      end
      res.ok       = 1'b1;
      res.out_id   = held[best].id;
      res.out_prio = top_prio;
      for (int unsigned i = best + 1; i < held_fill; i++) begin
        held[i - 1] = held[i];
      end
      held_fill--;
    end
    res.count    = 5'(held_fill);
    res.is_empty = (held_fill == 0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_fill = 0;
      awaited_res.delete();
      errs   = 0;
      res_no = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_res.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want_res = awaited_res.pop_front();
          check_field("ok", 32'(out_data_i.ok), 32'(want_res.ok));
          check_field("out_id", 32'(out_data_i.out_id), 32'(want_res.out_id));
          check_field("out_prio", out_data_i.out_prio, want_res.out_prio);
          check_field("count", 32'(out_data_i.count), 32'(want_res.count));
          check_field("is_empty", 32'(out_data_i.is_empty), 32'(want_res.is_empty));
        end
        res_no++;
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_res.push_back(apply_request(in_data_i));
      end
      err_count_o <= errs;
      pending_o   <= awaited_res.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for priority_queue_max_extract_core: clock, reset, request
// stimulus with random gaps, result back-pressure, watchdog and verdict.
// Depends on pqmx_pkg, the core and pqmx_checker.
module tb_top;
  import pqmx_pkg::*;

  // Slowest legal gap between two accepted transactions is roughly a sender
  // gap plus a full-queue dequeue plus a receiver stall; the idle limit is
  // that figure many times over.
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RAND_PHASES  = 13;
  localparam int unsigned PHASE_LEN    = 100;
  // settle time after the last result, above the worst dequeue latency
  localparam int unsigned SETTLE_CYCLES = 64;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pqmx_req_t   in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pqmx_res_t   out_data;

  int          err_count;
  int          pending;
  int unsigned stall_left  = 0;
  int unsigned stall_draw;
  int unsigned idle_cycles = 0;
  logic        rx_calm     = 1'b0;  // receiver draws no new stall while set
  logic        tx_calm     = 1'b0;  // sender sends back to back while set

  initial begin
    forever #1 clk = ~clk;
  end

  priority_queue_max_extract_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pqmx_checker u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // Result side: after each result taken, hold stall high for a
  // fresh random number of cycles. The stall is independent of out_valid,
  // so it also lands while the core is still scanning or shifting.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      stall_draw = rx_calm ? 0 : $urandom_range(11);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request after a random gap and return at the edge that takes it.
  // With a zero gap valid stays high and only the payload moves on.
  task automatic push_req(input pqmx_req_t req);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Stop sending until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic pqmx_req_t enq_req(input logic [15:0] id, input logic [31:0] prio);
    pqmx_req_t req;
    req.req_type = REQ_ENQ;
    req.proc_id  = id;
    req.prio     = prio;
    return req;
  endfunction

  // id and prio are don't-care on a dequeue; fill them anyway so they toggle
  function automatic pqmx_req_t deq_req();
    pqmx_req_t req;
    req.req_type = REQ_DEQ;
    req.proc_id  = 16'($urandom);
    req.prio     = $urandom;
    return req;
  endfunction

  // 0: full range, 1: tiny range to force ties, 2: boundary values
  function automatic logic [31:0] draw_prio(input int unsigned mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(3);
      default: begin
        case ($urandom_range(3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] draw_id(input int unsigned mode);
    if (mode == 2 && $urandom_range(1) == 0) begin
      return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
    end
    return 16'($urandom);
  endfunction

  initial begin
    int unsigned enq_pct;
    int unsigned prio_mode;
    pqmx_req_t   req;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: dequeue on empty, extremes of id and prio, ties at the top
    // and in the middle (oldest must win), then empty again.
    push_req(deq_req());
    push_req(enq_req(16'hFFFF, 32'hFFFF_FFFF));
    push_req(enq_req(16'h0000, 32'h0000_0000));
    push_req(enq_req(16'h1234, 32'hFFFF_FFFF));
    push_req(enq_req(16'hA5A5, 32'h0000_0007));
    push_req(enq_req(16'h5A5A, 32'h0000_0007));
    push_req(enq_req(16'h0001, 32'h8000_0000));
    repeat (6) push_req(deq_req());
    push_req(deq_req());
    wait_drained();

    // Random phases: enqueue-heavy phases run the queue full and into the
    // refused-enqueue case, dequeue-heavy ones empty it and hit dequeue on
    // empty. Idling is switched off now and then for back-to-back stretches.
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        2:       enq_pct = 15;
        default: enq_pct = $urandom_range(20, 80);
      endcase
      prio_mode = ph % 3;
      tx_calm   = ($urandom_range(3) == 0);
      rx_calm  <= ($urandom_range(3) == 0);
      for (int unsigned k = 0; k < PHASE_LEN; k++) begin
        if ($urandom_range(99) < enq_pct) begin
          req = enq_req(draw_id(prio_mode), draw_prio(prio_mode));
        end else begin
          req = deq_req();
        end
        push_req(req);
      end
      // let the pipeline run dry every few phases
      if (ph % 3 == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
